@@ rtl/core/perspective_plane_texcoord_gen_macros.svh @@
// Assertion macros for the perspective plane texture coordinate generator.
// Taken in by the top level; needs nothing else.
`ifndef PERSPECTIVE_PLANE_TEXCOORD_GEN_MACROS_SVH
`define PERSPECTIVE_PLANE_TEXCOORD_GEN_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PPTG_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PPTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PPTG_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define PPTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/pptg_pkg.sv @@
// Shared types, constants and the quarter sine table of the texture coordinate generator.
// No dependencies.
package pptg_pkg;

    localparam int MAX_SCREEN_WIDTH = 4096;
    localparam int MAX_HALF_HEIGHT  = 2048;
    localparam int COORD_FRAC_BITS  = 16;
    localparam int ANGLE_BITS       = 16;

    localparam int ROW_W      = 11;
    localparam int COL_W      = 12;
    localparam int WID_W      = 13;
    localparam int HALF_W     = 12;
    localparam int ROW_NUM_W  = 43;
    localparam int SPAN_W     = 46;
    localparam int WID_NUM_W  = 57;

    localparam logic [15:0] ANGLE_MASK = 16'hFFFF << (16 - ANGLE_BITS);
    localparam logic [31:0] FRAC_MASK  = (32'd1 << COORD_FRAC_BITS) - 32'd1;

    localparam logic [2:0] REG_CAM_X     = 3'd0;
    localparam logic [2:0] REG_CAM_Y     = 3'd1;
    localparam logic [2:0] REG_CAM_ANGLE = 3'd2;
    localparam logic [2:0] REG_FOV_HALF  = 3'd3;
    localparam logic [2:0] REG_NEAR      = 3'd4;
    localparam logic [2:0] REG_FAR       = 3'd5;
    localparam logic [2:0] REG_WIDTH     = 3'd6;
    localparam logic [2:0] REG_HALF      = 3'd7;

    typedef logic [31:0] t_corners [8];

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] ground;
        logic [11:0] sky;
        logic        inv;
    } t_side;

    function automatic logic [16:0] sine_tab(input logic [4:0] idx);
        logic [16:0] v;
        unique case (idx)
            5'd0:  v = 17'd0;
            5'd1:  v = 17'd6424;
            5'd2:  v = 17'd12785;
            5'd3:  v = 17'd19024;
            5'd4:  v = 17'd25080;
            5'd5:  v = 17'd30893;
            5'd6:  v = 17'd36410;
            5'd7:  v = 17'd41576;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd50660;
            5'd10: v = 17'd54491;
            5'd11: v = 17'd57798;
            5'd12: v = 17'd60547;
            5'd13: v = 17'd62714;
            5'd14: v = 17'd64277;
            5'd15: v = 17'd65220;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // Fractional part with the sign of the wrapped position kept.
    function automatic logic [16:0] frac_signed(input logic [31:0] v);
        logic [31:0] m;
        logic [31:0] t;
        m = (32'd0 - v) & FRAC_MASK;
        if (v[31]) begin
            t = 32'd0 - m;
        end else begin
            t = v & FRAC_MASK;
        end
        return t[16:0];
    endfunction

endpackage

@@ rtl/core/pptg_div_cell.sv @@
// One restoring division step: takes the next numerator bit and yields one quotient bit.
// Depends on nothing else.
module pptg_div_cell #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [NUM_W-1:0] i_quo,
    input  logic [DEN_W-1:0] i_den,
    output logic [DEN_W-1:0] o_rem,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_den
);
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {i_rem, i_quo[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});
    assign w_diff  = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {i_quo[NUM_W-2:0], w_ge};
            r_den <= i_den;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_den = r_den;
endmodule

@@ rtl/core/pptg_div_chain.sv @@
// Row of division cells, one quotient bit per cell, a new request every cycle while i_en is high.
// Depends on pptg_div_cell.
module pptg_div_chain #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);
    logic [DEN_W-1:0] w_rem [NUM_W+1];
    logic [NUM_W-1:0] w_quo [NUM_W+1];
    logic [DEN_W-1:0] w_den [NUM_W+1];

    assign w_rem[0] = '0;
    assign w_quo[0] = i_num;
    assign w_den[0] = i_den;

    for (genvar k = 0; k < NUM_W; k++) begin : g_cell
        pptg_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem[k]),
            .i_quo (w_quo[k]),
            .i_den (w_den[k]),
            .o_rem (w_rem[k+1]),
            .o_quo (w_quo[k+1]),
            .o_den (w_den[k+1])
        );
    end

    assign o_quo = w_quo[NUM_W];
    assign o_rem = w_rem[NUM_W];
endmodule

@@ rtl/core/pptg_delay.sv @@
// Shift line that carries a request's side data and valid flag alongside a division chain.
// Depends on nothing else.
module pptg_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic         r_v [DEPTH];
    logic [W-1:0] r_d [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_tap
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[k] <= (k == 0) ? i_data : r_d[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_valid = r_v[DEPTH-1];
    assign o_data  = r_d[DEPTH-1];
endmodule

@@ rtl/core/pptg_corner_gen.sv @@
// Sequencer that forms the eight frustum corner coordinates from the camera registers.
// Depends on pptg_pkg for the sine table and corner type.
module pptg_corner_gen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_cam_x,
    input  logic [31:0]        i_cam_y,
    input  logic [15:0]        i_cam_angle,
    input  logic [13:0]        i_fov_half,
    input  logic [23:0]        i_near,
    input  logic [23:0]        i_far,
    output logic               o_busy,
    output pptg_pkg::t_corners o_corner
);
    import pptg_pkg::*;

    logic        r_busy;
    logic [3:0]  r_cnt;

    logic        w_issue;
    logic [2:0]  w_idx;
    logic [15:0] w_ang;
    logic [15:0] w_ph;
    logic [14:0] w_r;
    logic [16:0] w_base;
    logic [16:0] w_next;

    logic        r_a_v, r_b_v, r_c_v;
    logic [2:0]  r_a_idx, r_b_idx, r_c_idx;
    logic [16:0] r_a_base;
    logic [12:0] r_a_diff;
    logic [9:0]  r_a_f;
    logic        r_a_neg;
    logic signed [17:0] r_b_trig;
    logic signed [42:0] r_c_p;

    logic [22:0] w_prod;
    logic [16:0] w_v;
    logic [23:0] w_dist;
    logic [42:0] w_mag;
    logic [42:0] w_rnd;
    logic [31:0] w_off;

    t_corners    r_corner;

    // The pass also runs after reset, so the corners match the reset registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 4'd11) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    assign w_issue = r_busy && !r_cnt[3];
    assign w_idx   = r_cnt[2:0];
    assign w_ang   = w_idx[2] ? (i_cam_angle + {2'b00, i_fov_half})
                              : (i_cam_angle - {2'b00, i_fov_half});
    assign w_ph    = (w_ang + (w_idx[0] ? 16'd0 : 16'd16384)) & ANGLE_MASK;
    assign w_r     = w_ph[14] ? (15'd16384 - {1'b0, w_ph[13:0]}) : {1'b0, w_ph[13:0]};
    assign w_base  = sine_tab(w_r[14:10]);
    assign w_next  = sine_tab(w_r[14:10] + 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_a_v <= w_issue;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    assign w_prod = r_a_diff * r_a_f;
    assign w_v    = r_a_base + {3'b000, 14'((w_prod + 23'd512) >> 10)};
    assign w_dist = r_b_idx[1] ? i_near : i_far;
    assign w_mag  = r_c_p[42] ? 43'(-r_c_p) : 43'(r_c_p);
    assign w_rnd  = (w_mag + 43'd32768) >> 16;
    assign w_off  = r_c_p[42] ? (32'd0 - w_rnd[31:0]) : w_rnd[31:0];

    always_ff @(posedge i_clk) begin
        r_a_idx  <= w_idx;
        r_a_base <= w_base;
        r_a_diff <= 13'(w_next - w_base);
        r_a_f    <= w_r[9:0];
        r_a_neg  <= w_ph[15];
        r_b_idx  <= r_a_idx;
        r_b_trig <= r_a_neg ? -$signed({1'b0, w_v}) : $signed({1'b0, w_v});
        r_c_idx  <= r_b_idx;
        r_c_p    <= $signed({1'b0, w_dist}) * r_b_trig;
        if (r_c_v) begin
            r_corner[r_c_idx] <= (r_c_idx[0] ? i_cam_y : i_cam_x) + w_off;
        end
    end

    assign o_busy   = r_busy;
    assign o_corner = r_corner;
endmodule

@@ rtl/core/perspective_plane_texcoord_gen.sv @@
// Perspective floor texture coordinate generator: one pixel request per clock unless the
// output stalls or a corner pass runs. Between a request and its result lie two restoring
// division chains (43 cells dividing by the row, 57 cells dividing by the screen width) plus
// five registered stages, the first of which loads at the accepting edge. After reset and
// after every register write a corner pass runs, during which no pixel is taken.
// A stalled output holds the whole pipeline. Depends on pptg_pkg and the modules below it.
`include "perspective_plane_texcoord_gen_macros.svh"
module perspective_plane_texcoord_gen (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_pixel_col,
    input  logic [10:0] i_depth_row,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_out_col,
    output logic [11:0] o_ground_row,
    output logic [11:0] o_sky_row,
    output logic signed [16:0] o_tex_u,
    output logic signed [16:0] o_tex_v,
    output logic        o_row_invalid
);
    import pptg_pkg::*;

    logic [31:0] r_cam_x, r_cam_y;
    logic [15:0] r_cam_angle;
    logic [13:0] r_fov_half;
    logic [23:0] r_near, r_far;
    logic [12:0] r_width;
    logic [11:0] r_half;

    logic        w_wr;
    logic        w_busy;
    t_corners    w_corner;
    logic        w_en;
    logic        w_accept;
    logic [11:0] w_half;
    logic [12:0] w_width;
    logic [12:0] w_ground;

    logic        r1_v;
    logic [10:0] r1_row;
    t_side       r1_side;
    logic        w_a_v;
    t_side       w_a_side;
    logic        r2_v, r3_v, r4_v;
    t_side       r2_side, r3_side, r4_side;
    logic        w_b_v;
    logic [102:0] w_b_data;
    logic        r_out_v;

    logic [31:0] w_ql4 [2];
    logic        w_neg4 [2];
    logic [WID_NUM_W-1:0] w_wq [2];
    logic [16:0] w_tex [2];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x     <= '0;
            r_cam_y     <= '0;
            r_cam_angle <= '0;
            r_fov_half  <= 14'd8192;
            r_near      <= 24'd327;
            r_far       <= 24'd65536;
            r_width     <= 13'd640;
            r_half      <= 12'd240;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_CAM_X:     r_cam_x     <= pwdata;
                REG_CAM_Y:     r_cam_y     <= pwdata;
                REG_CAM_ANGLE: r_cam_angle <= pwdata[15:0];
                REG_FOV_HALF:  r_fov_half  <= pwdata[13:0];
                REG_NEAR:      r_near      <= pwdata[23:0];
                REG_FAR:       r_far       <= pwdata[23:0];
                REG_WIDTH:     r_width     <= pwdata[12:0];
                REG_HALF:      r_half      <= pwdata[11:0];
                default:       r_half      <= r_half;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_CAM_X:     prdata = r_cam_x;
            REG_CAM_Y:     prdata = r_cam_y;
            REG_CAM_ANGLE: prdata = {16'd0, r_cam_angle};
            REG_FOV_HALF:  prdata = {18'd0, r_fov_half};
            REG_NEAR:      prdata = {8'd0, r_near};
            REG_FAR:       prdata = {8'd0, r_far};
            REG_WIDTH:     prdata = {19'd0, r_width};
            REG_HALF:      prdata = {20'd0, r_half};
            default:       prdata = '0;
        endcase
    end

    pptg_corner_gen u_corner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_wr),
        .i_cam_x     (r_cam_x),
        .i_cam_y     (r_cam_y),
        .i_cam_angle (r_cam_angle),
        .i_fov_half  (r_fov_half),
        .i_near      (r_near),
        .i_far       (r_far),
        .o_busy      (w_busy),
        .o_corner    (w_corner)
    );

    assign w_half  = (r_half == 12'd0) ? 12'd1 :
                     (r_half > 12'(MAX_HALF_HEIGHT)) ? 12'(MAX_HALF_HEIGHT) : r_half;
    assign w_width = (r_width == 13'd0) ? 13'd1 :
                     (r_width > 13'(MAX_SCREEN_WIDTH)) ? 13'(MAX_SCREEN_WIDTH) : r_width;

    assign w_en       = !r_out_v || i_out_ready;
    assign o_in_ready = w_en && !w_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ground   = {1'b0, w_half} + {2'b00, i_depth_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_accept;
            r2_v <= w_a_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_out_v <= w_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_row         <= i_depth_row;
            r1_side.col    <= i_pixel_col;
            r1_side.ground <= w_ground[12] ? 12'd4095 : w_ground[11:0];
            r1_side.sky    <= ({1'b0, i_depth_row} > w_half) ? 12'd0
                              : (w_half - {1'b0, i_depth_row});
            r1_side.inv    <= (i_depth_row == 11'd0);
            r2_side <= w_a_side;
            r3_side <= r2_side;
            r4_side <= r3_side;
        end
    end

    pptg_delay #(.W($bits(t_side)), .DEPTH(ROW_NUM_W)) u_delay_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_v),
        .i_data  (r1_side),
        .o_valid (w_a_v),
        .o_data  (w_a_side)
    );

    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic [31:0] r_dl_mag, r_dr_mag, r_dn, r_nl;
        logic        r_dl_neg, r_dr_neg;
        logic [31:0] w_dl, w_dr;
        logic [ROW_NUM_W-1:0] r1_numl, r1_numr;
        logic [ROW_NUM_W-1:0] w_ql, w_qr;
        logic signed [ROW_NUM_W:0] r2_ql, r2_qr;
        logic signed [SPAN_W-1:0]  w_span;
        logic [SPAN_W-2:0] r3_mag;
        logic        r3_neg;
        logic [31:0] r3_ql, r4_ql;
        logic [WID_NUM_W-1:0] r4_prod;
        logic        r4_neg;
        logic [31:0] w_wq32;
        logic [31:0] w_sample;

        // Corners only change during the corner pass, when no pixel is taken.
        assign w_dl = w_corner[a] - w_corner[2+a];
        assign w_dr = w_corner[4+a] - w_corner[6+a];
        always_ff @(posedge i_clk) begin
            r_dl_mag <= w_dl[31] ? (32'd0 - w_dl) : w_dl;
            r_dl_neg <= w_dl[31];
            r_dr_mag <= w_dr[31] ? (32'd0 - w_dr) : w_dr;
            r_dr_neg <= w_dr[31];
            r_dn     <= w_corner[6+a] - w_corner[2+a];
            r_nl     <= w_corner[2+a];
        end

        pptg_div_chain #(.NUM_W(ROW_NUM_W), .DEN_W(ROW_W)) u_div_l (
            .i_clk (i_clk), .i_en (w_en), .i_num (r1_numl), .i_den (r1_row),
            .o_quo (w_ql), .o_rem ()
        );
        pptg_div_chain #(.NUM_W(ROW_NUM_W), .DEN_W(ROW_W)) u_div_r (
            .i_clk (i_clk), .i_en (w_en), .i_num (r1_numr), .i_den (r1_row),
            .o_quo (w_qr), .o_rem ()
        );

        assign w_span = $signed({{(SPAN_W-32){r_dn[31]}}, r_dn})
                      + $signed({{(SPAN_W-ROW_NUM_W-1){r2_qr[ROW_NUM_W]}}, r2_qr})
                      - $signed({{(SPAN_W-ROW_NUM_W-1){r2_ql[ROW_NUM_W]}}, r2_ql});

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r1_numl <= {{(ROW_NUM_W-32){1'b0}}, r_dl_mag} * w_half;
                r1_numr <= {{(ROW_NUM_W-32){1'b0}}, r_dr_mag} * w_half;
                r2_ql   <= r_dl_neg ? -$signed({1'b0, w_ql}) : $signed({1'b0, w_ql});
                r2_qr   <= r_dr_neg ? -$signed({1'b0, w_qr}) : $signed({1'b0, w_qr});
                r3_mag  <= w_span[SPAN_W-1] ? (SPAN_W-1)'(-w_span) : (SPAN_W-1)'(w_span);
                r3_neg  <= w_span[SPAN_W-1];
                r3_ql   <= r2_ql[31:0];
                r4_prod <= {{(WID_NUM_W-SPAN_W+1){1'b0}}, r3_mag} * r3_side.col;
                r4_neg  <= r3_neg;
                r4_ql   <= r3_ql;
            end
        end

        pptg_div_chain #(.NUM_W(WID_NUM_W), .DEN_W(WID_W)) u_div_w (
            .i_clk (i_clk), .i_en (w_en), .i_num (r4_prod), .i_den (w_width),
            .o_quo (w_wq[a]), .o_rem ()
        );

        assign w_ql4[a]  = r4_ql;
        assign w_neg4[a] = r4_neg;

        // Positions wrap modulo one 32-bit word, so only the low word is summed.
        assign w_wq32   = w_b_data[32+33*a] ? (32'd0 - w_wq[a][31:0]) : w_wq[a][31:0];
        assign w_sample = r_nl + w_b_data[31+33*a -: 32] + w_wq32;
        assign w_tex[a] = frac_signed(w_sample);
    end

    pptg_delay #(.W(103), .DEPTH(WID_NUM_W)) u_delay_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_data  ({r4_side, w_neg4[1], w_ql4[1], w_neg4[0], w_ql4[0]}),
        .o_valid (w_b_v),
        .o_data  (w_b_data)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out_col     <= w_b_data[102:91];
            o_ground_row  <= w_b_data[90:79];
            o_sky_row     <= w_b_data[78:67];
            o_row_invalid <= w_b_data[66];
            o_tex_u       <= w_b_data[66] ? 17'sd0 : $signed(w_tex[0]);
            o_tex_v       <= w_b_data[66] ? 17'sd0 : $signed(w_tex[1]);
        end
    end

    assign o_out_valid = r_out_v;

    `PPTG_ASSERT_SAME(a_busy_blocks_input, i_clk, i_rst_n, w_busy, !o_in_ready)
    `PPTG_ASSERT_NEXT(a_write_starts_pass, i_clk, i_rst_n, w_wr, w_busy)
    `PPTG_ASSERT_SAME(a_horizon_zero, i_clk, i_rst_n, o_out_valid && o_row_invalid, o_tex_u == 17'sd0 && o_tex_v == 17'sd0)
endmodule
